FILE: rtl/msrf_pkg.sv
// Shared constants, codes and handshake structs for the masked span row fill block.
// Used by the controller, the datapath and the top level.
package msrf_pkg;

    localparam int FULL_ROW_CELLS = 10;
    localparam int MAX_RESULTS    = 20;
    localparam int SOLID_RAW      = 2 * FULL_ROW_CELLS;
    localparam int SOLID_COUNT    = (SOLID_RAW < MAX_RESULTS) ? SOLID_RAW : MAX_RESULTS;

    // result counter and result count widths
    localparam int IDX_W = $clog2(MAX_RESULTS);
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    localparam int TAB_DEPTH = 16;
    localparam int TAB_W     = $clog2(TAB_DEPTH);

    localparam logic [7:0]  WIDTH_LIMIT  = 8'd160;
    localparam logic [15:0] COL_MASK     = 16'hfff8;
    localparam logic [31:0] STATUS_MULTI = 32'h0000ffff;

    localparam logic ACT_DRAW   = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_OBJECT_WIDTH = 2'd0;
    localparam logic [1:0] REG_FILL_LOW     = 2'd1;
    localparam logic [1:0] REG_FILL_HIGH    = 2'd2;

    typedef struct packed {
        logic             accept;
        logic             emit;
        logic [IDX_W-1:0] idx;
        logic             last;
    } msrf_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] total;
    } msrf_status_t;

endpackage

FILE: rtl/masked_span_row_fill.sv
// Masked span row fill: top level joining the row sequencer and the datapath.
// Depends on msrf_pkg, msrf_ctrl and msrf_datapath.
//
// Each draw item produces between one and twenty 64-bit cell writes for one scanline:
// a solid row, a single no-write result for a row off the edge, or a masked edge cell
// followed by solid interior cells. A draw item is accepted from idle and its results
// then pass in order through the single output register, which holds a result while
// the sink stalls; the next item is taken once the last result has entered the output
// register. A mask table load produces no result. The two 16-entry keep mask tables
// come up undefined and must be loaded before a row reads them. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
module masked_span_row_fill
    import msrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic        anchor_side,
    input  logic [31:0] row_address,
    input  logic [15:0] x_pos,
    input  logic [3:0]  mask_entry,
    input  logic [31:0] mask_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_valid,
    output logic [31:0] write_address,
    output logic [63:0] write_data,
    output logic [31:0] keep_mask,
    output logic [31:0] row_status,
    output logic        last
);

    msrf_cmd_t    cmd;
    msrf_status_t status;

    msrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

    msrf_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .anchor_side   (anchor_side),
        .row_address   (row_address),
        .x_pos         (x_pos),
        .mask_entry    (mask_entry),
        .mask_word     (mask_word),
        .cmd           (cmd),
        .status        (status),
        .write_valid   (write_valid),
        .write_address (write_address),
        .write_data    (write_data),
        .keep_mask     (keep_mask),
        .row_status    (row_status),
        .last          (last)
    );

endmodule

FILE: rtl/msrf_ctrl.sv
// Row sequencer for the masked span row fill block: accepts items and steps the result index.
// Depends on msrf_pkg for the command and status structs.
module msrf_ctrl
    import msrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         action,
    output logic         in_stall,
    input  logic         out_stall,
    output logic         out_valid,
    output msrf_cmd_t    cmd,
    input  msrf_status_t status
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             emit;
    logic             last;

    always_comb
    begin
        accept = in_valid && (state_reg == ST_IDLE);
        emit   = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
        last   = (CNT_W'(idx_reg) == (status.total - CNT_W'(1)));

        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_DRAW))
                begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    if (last)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold a result the sink has not taken yet
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.accept = accept;
    assign cmd.emit   = emit;
    assign cmd.idx    = idx_reg;
    assign cmd.last   = last;

endmodule

FILE: rtl/msrf_datapath.sv
// Datapath of the masked span row fill block: config registers, keep mask tables,
// row classification and the output register. Depends on msrf_pkg.
module msrf_datapath
    import msrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         action,
    input  logic         anchor_side,
    input  logic [31:0]  row_address,
    input  logic [15:0]  x_pos,
    input  logic [3:0]   mask_entry,
    input  logic [31:0]  mask_word,
    input  msrf_cmd_t    cmd,
    output msrf_status_t status,
    output logic         write_valid,
    output logic [31:0]  write_address,
    output logic [63:0]  write_data,
    output logic [31:0]  keep_mask,
    output logic [31:0]  row_status,
    output logic         last
);

    typedef enum logic [1:0] {
        MODE_EMPTY,
        MODE_SOLID,
        MODE_EDGE
    } mode_t;

    logic [7:0]  width_reg;
    logic [31:0] fill_lo_reg;
    logic [31:0] fill_hi_reg;

    logic [31:0] left_tab  [TAB_DEPTH];
    logic [31:0] right_tab [TAB_DEPTH];

    // per-row state, loaded when a draw item is accepted
    logic             side_reg;
    logic [31:0]      base_reg;
    logic [7:0]       col_reg;
    mode_t            mode_reg;
    logic [CNT_W-1:0] total_reg;
    logic [31:0]      stat_reg;
    logic             stat_mask_reg;
    logic [31:0]      mask_reg;

    // output register
    logic        wv_reg;
    logic [31:0] addr_reg;
    logic [63:0] data_reg;
    logic [31:0] keep_reg;
    logic [31:0] rstat_reg;
    logic        last_reg;

    // classification of the incoming row
    logic [7:0]       w;
    logic [15:0]      half;
    logic [15:0]      col;
    logic [15:0]      diff;
    logic [8:0]       right_span;
    mode_t            mode_in;
    logic [CNT_W-1:0] total_in;
    logic [31:0]      stat_in;
    logic             stat_mask_in;

    always_comb
    begin
        w          = (width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : width_reg;
        half       = {x_pos[15], x_pos[15:1]};
        col        = half & COL_MASK;
        diff       = col - {8'd0, w};
        right_span = {1'b0, w} - {1'b0, col[7:0]} + 9'd7;

        mode_in      = MODE_EDGE;
        total_in     = CNT_W'(1);
        stat_in      = 32'd0;
        stat_mask_in = 1'b0;
        if (anchor_side == SIDE_LEFT)
        begin
            if (col[15])
            begin
                mode_in = MODE_EMPTY;
                stat_in = {16'd0, col};
            end
            else if (!diff[15])
            begin
                mode_in  = MODE_SOLID;
                total_in = CNT_W'(SOLID_COUNT);
                stat_in  = {16'd0, diff};
            end
            else
            begin
                // edge cell plus one interior cell per eight bytes left of it
                total_in     = CNT_W'(col[7:3]) + CNT_W'(1);
                stat_in      = STATUS_MULTI;
                stat_mask_in = (col[7:3] == 5'd0);
            end
        end
        else
        begin
            if (col[15])
            begin
                mode_in  = MODE_SOLID;
                total_in = CNT_W'(SOLID_COUNT);
            end
            else if (!diff[15])
            begin
                mode_in = MODE_EMPTY;
            end
            else
            begin
                // cells from the edge up to the object width, rounded up
                total_in = CNT_W'(right_span[7:3]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_LIMIT;
            fill_lo_reg <= 32'd0;
            fill_hi_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OBJECT_WIDTH: width_reg   <= cfg_data[7:0];
                REG_FILL_LOW:     fill_lo_reg <= cfg_data;
                REG_FILL_HIGH:    fill_hi_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (action == ACT_LOAD)
            begin
                if (anchor_side == SIDE_LEFT)
                    left_tab[mask_entry] <= mask_word;
                else
                    right_tab[mask_entry] <= mask_word;
            end
            else
            begin
                mask_reg <= (anchor_side == SIDE_LEFT) ? left_tab[x_pos[TAB_W-1:0]]
                                                       : right_tab[x_pos[TAB_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_EMPTY;
            total_reg <= CNT_W'(1);
        end
        else if (cmd.accept && (action == ACT_DRAW))
        begin
            mode_reg  <= mode_in;
            total_reg <= total_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (action == ACT_DRAW))
        begin
            side_reg      <= anchor_side;
            base_reg      <= row_address;
            col_reg       <= col[7:0];
            stat_reg      <= stat_in;
            stat_mask_reg <= stat_mask_in;
        end
    end

    // result for the current index
    logic [15:0] cell_off;
    logic [15:0] off;
    logic        res_wv;
    logic [31:0] res_keep;
    logic [31:0] res_stat;

    always_comb
    begin
        cell_off = {{(13 - IDX_W){1'b0}}, cmd.idx, 3'b000};
        off      = 16'd0;
        res_wv   = 1'b1;
        res_keep = 32'd0;
        case (mode_reg)
            MODE_EMPTY:
            begin
                res_wv = 1'b0;
            end
            MODE_SOLID:
            begin
                off = cell_off;
            end
            MODE_EDGE:
            begin
                if (cmd.idx == '0)
                begin
                    off      = {8'd0, col_reg};
                    res_keep = mask_reg;
                end
                else if (side_reg == SIDE_LEFT)
                    off = cell_off - 16'd8;
                else
                    off = {8'd0, col_reg} + cell_off;
            end
            default:
            begin
                res_wv = 1'b0;
            end
        endcase

        res_stat = stat_mask_reg ? mask_reg : stat_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            wv_reg    <= res_wv;
            addr_reg  <= res_wv ? (base_reg + {16'd0, off}) : 32'd0;
            data_reg  <= res_wv ? {fill_lo_reg, fill_hi_reg} : 64'd0;
            keep_reg  <= res_keep;
            rstat_reg <= cmd.last ? res_stat : 32'd0;
            last_reg  <= cmd.last;
        end
    end

    assign status.total  = total_reg;
    assign write_valid   = wv_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign keep_mask     = keep_reg;
    assign row_status    = rstat_reg;
    assign last          = last_reg;

endmodule

FILE: rtl/msrf_checker.sv
// Port-level checks for masked_span_row_fill, attached by the bind below.
// Depends only on the top level's ports.
module msrf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        write_valid,
    input logic [31:0] write_address,
    input logic [63:0] write_data,
    input logic [31:0] keep_mask,
    input logic [31:0] row_status,
    input logic        last
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(write_address) &&
        $stable(write_data) && $stable(last) && $stable(row_status))
        else $error("stalled output item changed");

    // a result without a write always closes its row
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> last)
        else $error("no-write result is not last");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> write_address == 32'd0 && write_data == 64'd0 &&
        keep_mask == 32'd0)
        else $error("no-write result carries payload");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> row_status == 32'd0)
        else $error("status word before the last result");

endmodule

bind masked_span_row_fill msrf_checker u_msrf_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for masked_span_row_fill: a directed table of rows, then random phases.
// Predicts the cell writes from its own copy of the row rules and mask tables, or takes them from the directed table.
// Depends on msrf_pkg and the masked_span_row_fill RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msrf_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 30;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 28;

    typedef struct packed {
        logic        act;
        logic        side;
        logic [31:0] addr;
        logic [15:0] x;
        logic [3:0]  entry;
        logic [31:0] word;
    } span_cmd_t;

    typedef struct packed {
        logic        wr;
        logic [31:0] addr;
        logic [63:0] data;
        logic [31:0] keep;
        logic [31:0] status;
        logic        last;
    } cell_write_t;

    typedef enum {PLAN_ITEM, PLAN_DRAIN, PLAN_SETTINGS} plan_kind_t;

    typedef struct {
        plan_kind_t  kind;
        span_cmd_t   cmd;
        bit          typed;
        cell_write_t res;
        logic [7:0]  w;
        logic [31:0] lo;
        logic [31:0] hi;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = 1'b0;
    logic        anchor_side = 1'b0;
    logic [31:0] row_address = 32'd0;
    logic [15:0] x_pos = 16'd0;
    logic [3:0]  mask_entry = 4'd0;
    logic [31:0] mask_word = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        write_valid;
    logic [31:0] write_address;
    logic [63:0] write_data;
    logic [31:0] keep_mask;
    logic [31:0] row_status;
    logic        last;

    // predictor copy of the block's settings and tables
    logic [7:0]  set_width = WIDTH_LIMIT;
    logic [31:0] set_fill_low = 32'd0;
    logic [31:0] set_fill_high = 32'd0;
    logic [31:0] left_keep [16];
    logic [31:0] right_keep [16];
    bit          left_loaded [16];
    bit          right_loaded [16];

    cell_write_t pending_writes [$];
    plan_row_t   plan [$];

    bit bursts_on = 1'b1;
    int stall_left = 0;
    int mismatches = 0;
    int results_seen = 0;
    int draws_sent = 0;
    int loads_sent = 0;
    int settings_done = 0;

    masked_span_row_fill i_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [7:0] eff_width();
        return (set_width > WIDTH_LIMIT) ? WIDTH_LIMIT : set_width;
    endfunction

    // arithmetic shift by one in 16 bits, then align to the cell
    function automatic logic [15:0] span_col(logic [15:0] x);
        logic [15:0] half;
        half = {x[15], x[15:1]};
        return half & COL_MASK;
    endfunction

    function automatic bit reads_table(logic [15:0] x);
        logic [15:0] col;
        logic [15:0] diff;
        col  = span_col(x);
        diff = col - {8'h00, eff_width()};
        return !col[15] && diff[15];
    endfunction

    function automatic cell_write_t fill_cell(logic [31:0] addr, logic [31:0] keep);
        cell_write_t r;
        r        = '0;
        r.wr     = 1'b1;
        r.addr   = addr;
        r.data   = {set_fill_low, set_fill_high};
        r.keep   = keep;
        return r;
    endfunction

    function automatic cell_write_t no_write(logic [31:0] status);
        cell_write_t r;
        r        = '0;
        r.status = status;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic span_cmd_t draw_cmd(logic side, logic [31:0] addr, logic [15:0] x);
        span_cmd_t c;
        c      = '0;
        c.act  = ACT_DRAW;
        c.side = side;
        c.addr = addr;
        c.x    = x;
        return c;
    endfunction

    function automatic span_cmd_t load_cmd(logic side, logic [3:0] entry, logic [31:0] word);
        span_cmd_t c;
        c       = '0;
        c.act   = ACT_LOAD;
        c.side  = side;
        c.entry = entry;
        c.word  = word;
        return c;
    endfunction

    function automatic span_cmd_t any_cmd();
        span_cmd_t c;
        c.act   = 1'($urandom);
        c.side  = 1'($urandom);
        c.addr  = $urandom;
        c.x     = 16'($urandom);
        c.entry = 4'($urandom);
        c.word  = $urandom;
        return c;
    endfunction

    // Work out the cell writes one item causes and queue them; loads update the tables.
    function automatic void predict_span(span_cmd_t c);
        logic [15:0] col;
        logic [15:0] diff;
        logic [31:0] keep;
        logic [31:0] ptr;
        int          cells;
        int          remaining;
        cell_write_t burst [$];
        if (c.act == ACT_LOAD)
        begin
            if (c.side == SIDE_LEFT)
            begin
                left_keep[c.entry]   = c.word;
                left_loaded[c.entry] = 1'b1;
            end
            else
            begin
                right_keep[c.entry]   = c.word;
                right_loaded[c.entry] = 1'b1;
            end
            return;
        end
        col  = span_col(c.x);
        diff = col - {8'h00, eff_width()};
        if ((c.side == SIDE_LEFT) ? col[15] : (!col[15] && !diff[15]))
        begin
            pending_writes.push_back(no_write((c.side == SIDE_LEFT) ? {16'h0000, col} : 32'd0));
            return;
        end
        if ((c.side == SIDE_LEFT) ? !diff[15] : col[15])
        begin
            for (int k = 0; k < SOLID_COUNT; k++)
                burst.push_back(fill_cell(c.addr + 32'(8 * k), 32'd0));
            burst[burst.size() - 1].status = (c.side == SIDE_LEFT) ? {16'h0000, diff} : 32'd0;
        end
        else if (c.side == SIDE_LEFT)
        begin
            // edge cell first, then interior cells from the row base upward
            keep  = left_keep[c.x[3:0]];
            burst.push_back(fill_cell(c.addr + {16'h0000, col}, keep));
            cells = int'(col >> 3);
            for (int k = 0; k < cells && burst.size() < MAX_RESULTS; k++)
                burst.push_back(fill_cell(c.addr + 32'(8 * k), 32'd0));
            burst[burst.size() - 1].status = (cells == 0) ? keep : STATUS_MULTI;
        end
        else
        begin
            // edge cell, then advance right until the span covers the width
            keep = right_keep[c.x[3:0]];
            ptr  = c.addr + {16'h0000, col};
            burst.push_back(fill_cell(ptr, keep));
            remaining = int'(col) - int'(eff_width()) + 8;
            while (remaining < 0 && burst.size() < MAX_RESULTS)
            begin
                ptr = ptr + 32'd8;
                burst.push_back(fill_cell(ptr, 32'd0));
                remaining += 8;
            end
        end
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            pending_writes.push_back(burst[i]);
    endfunction

    // Some table loads, mostly rows that straddle the edge, some near small columns, some anything at all.
    function automatic span_cmd_t random_cmd();
        span_cmd_t   c;
        int          pick;
        int          wi;
        logic [15:0] col8;
        int          slots [$];
        c     = any_cmd();
        c.act = ACT_DRAW;
        pick  = int'($urandom_range(0, 9));
        wi    = int'(eff_width());
        if (pick < 2)
            c.act = ACT_LOAD;
        else if (pick < 7)
        begin
            if (wi != 0)
            begin
                col8 = 16'($urandom_range(0, (wi - 1) / 8) * 8);
                c.x  = {col8[14:3], c.x[3:0]};
            end
        end
        else if (pick < 9)
            c.x = {7'd0, c.x[8:0]};
        // never let a row read a table entry that was not loaded
        if (c.act == ACT_DRAW && reads_table(c.x))
        begin
            for (int i = 0; i < 16; i++)
                if ((c.side == SIDE_LEFT) ? left_loaded[i] : right_loaded[i])
                    slots.push_back(i);
            if (slots.size() == 0)
            begin
                c.act   = ACT_LOAD;
                c.entry = c.x[3:0];
            end
            else
                c.x[3:0] = 4'(slots[$urandom_range(0, slots.size() - 1)]);
        end
        return c;
    endfunction

    function automatic void plan_item(span_cmd_t c);
        plan_row_t r;
        r.kind  = PLAN_ITEM;
        r.cmd   = c;
        r.typed = 1'b0;
        r.res   = '0;
        r.w     = 8'd0;
        r.lo    = 32'd0;
        r.hi    = 32'd0;
        plan.push_back(r);
    endfunction

    function automatic void plan_checked(span_cmd_t c, cell_write_t res);
        plan_item(c);
        plan[plan.size() - 1].typed = 1'b1;
        plan[plan.size() - 1].res   = res;
    endfunction

    function automatic void plan_settings(logic [7:0] w, logic [31:0] lo, logic [31:0] hi);
        plan_item('0);
        plan[plan.size() - 1].kind = PLAN_SETTINGS;
        plan[plan.size() - 1].w    = w;
        plan[plan.size() - 1].lo   = lo;
        plan[plan.size() - 1].hi   = hi;
    endfunction

    function automatic void plan_drain();
        plan_item('0);
        plan[plan.size() - 1].kind = PLAN_DRAIN;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at result %0d, %s: got %h, want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic drive_payload(span_cmd_t c);
        action      = c.act;
        anchor_side = c.side;
        row_address = c.addr;
        x_pos       = c.x;
        mask_entry  = c.entry;
        mask_word   = c.word;
    endtask

    // Starts and ends at a falling edge; in_valid stays high unless a gap follows.
    task automatic send_cmd(span_cmd_t c, bit typed, cell_write_t res);
        drive_payload(c);
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (typed)
            pending_writes.push_back(res);
        else
            predict_span(c);
        if (c.act == ACT_LOAD)
            loads_sent++;
        else
            draws_sent++;
        @(negedge clk);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            drive_payload(any_cmd());
            repeat ($urandom_range(1, 17))
                @(negedge clk);
        end
    endtask

    task automatic wait_for_writes();
        in_valid = 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_settings(logic [7:0] w, logic [31:0] lo, logic [31:0] hi);
        logic [31:0] junk;
        junk = $urandom;
        wait_for_writes();
        // a trailing load leaves no result to wait on
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = REG_OBJECT_WIDTH;
        cfg_data  = {junk[31:8], w};
        @(negedge clk);
        cfg_index = REG_FILL_LOW;
        cfg_data  = lo;
        @(negedge clk);
        cfg_index = REG_FILL_HIGH;
        cfg_data  = hi;
        @(negedge clk);
        cfg_write     = 1'b0;
        set_width     = w;
        set_fill_low  = lo;
        set_fill_high = hi;
        settings_done++;
    endtask

    // receiver: random stall bursts
    always @(negedge clk)
    begin
        if (bursts_on && stall_left > 0)
        begin
            stall_left--;
            out_stall = 1'b1;
        end
        else if (bursts_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = int'($urandom_range(1, 17)) - 1;
            out_stall  = 1'b1;
        end
        else
        begin
            stall_left = 0;
            out_stall  = 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_writes
        cell_write_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_writes.size() == 0)
                report_mismatch("result with none expected", 64'(write_address), 64'd0);
            else
            begin
                want = pending_writes.pop_front();
                if (write_valid !== want.wr)
                    report_mismatch("write_valid", 64'(write_valid), 64'(want.wr));
                if (write_address !== want.addr)
                    report_mismatch("write_address", 64'(write_address), 64'(want.addr));
                if (write_data !== want.data)
                    report_mismatch("write_data", write_data, want.data);
                if (keep_mask !== want.keep)
                    report_mismatch("keep_mask", 64'(keep_mask), 64'(want.keep));
                if (row_status !== want.status)
                    report_mismatch("row_status", 64'(row_status), 64'(want.status));
                if (last !== want.last)
                    report_mismatch("last", 64'(last), 64'(want.last));
            end
        end
    end

    initial
    begin
        logic [7:0] w;
        for (int i = 0; i < 16; i++)
        begin
            left_keep[i]    = 32'd0;
            right_keep[i]   = 32'd0;
            left_loaded[i]  = 1'b0;
            right_loaded[i] = 1'b0;
        end

        // reset settings: width 160, fill words zero
        plan_checked(draw_cmd(SIDE_LEFT, 32'h0000_1000, 16'h8000), no_write(32'h0000_c000));
        plan_checked(draw_cmd(SIDE_RIGHT, 32'hffff_ffff, 16'h0140), no_write(32'd0));
        plan_checked(draw_cmd(SIDE_LEFT, 32'h0000_0000, 16'hffff), no_write(32'h0000_fff8));
        plan_item(load_cmd(SIDE_LEFT, 4'd0, 32'hffff_ffff));
        plan_item(load_cmd(SIDE_LEFT, 4'd15, 32'h0000_0000));
        plan_item(load_cmd(SIDE_RIGHT, 4'd15, 32'hffff_ffff));
        plan_item(load_cmd(SIDE_RIGHT, 4'd0, 32'ha5a5_5a5a));
        plan_item(load_cmd(SIDE_LEFT, 4'd5, 32'h0f0f_0f0f));
        plan_item(draw_cmd(SIDE_LEFT, 32'h0000_0000, 16'h0000));
        plan_item(draw_cmd(SIDE_LEFT, 32'h8000_0000, 16'h013f));
        plan_item(draw_cmd(SIDE_LEFT, 32'h1234_5678, 16'h0140));
        plan_item(draw_cmd(SIDE_RIGHT, 32'hffff_fff0, 16'hffff));
        plan_item(draw_cmd(SIDE_RIGHT, 32'h0000_0100, 16'h0000));
        plan_item(draw_cmd(SIDE_RIGHT, 32'hffff_ffc0, 16'h012f));
        plan_drain();
        // zero width: every non-negative column is solid on the left, empty on the right
        plan_settings(8'd0, 32'hffff_ffff, 32'h0000_0000);
        plan_item(draw_cmd(SIDE_LEFT, 32'h0000_2000, 16'h0000));
        plan_checked(draw_cmd(SIDE_RIGHT, 32'h0000_2000, 16'h0000), no_write(32'd0));
        // width above the limit clamps to 160
        plan_settings(8'd255, 32'h0000_0000, 32'hffff_ffff);
        plan_item(draw_cmd(SIDE_LEFT, 32'h0000_4000, 16'h0125));
        plan_checked(draw_cmd(SIDE_RIGHT, 32'h0000_4000, 16'h7fff), no_write(32'd0));
        plan_settings(8'd1, 32'h89ab_cdef, 32'h0123_4567);
        plan_item(draw_cmd(SIDE_LEFT, 32'h0000_8000, 16'h0010));
        plan_item(draw_cmd(SIDE_RIGHT, 32'h0000_8000, 16'h000f));
        plan_item(load_cmd(SIDE_RIGHT, 4'd5, 32'h8000_0001));
        plan_drain();

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            case (plan[i].kind)
                PLAN_ITEM:     send_cmd(plan[i].cmd, plan[i].typed, plan[i].res);
                PLAN_DRAIN:    wait_for_writes();
                PLAN_SETTINGS: load_settings(plan[i].w, plan[i].lo, plan[i].hi);
                default:       ;
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       w = 8'($urandom_range(8, 160));
                1:       w = WIDTH_LIMIT;
                2:       w = 8'($urandom_range(1, 40));
                3:       w = 8'($urandom);
                default: w = 8'($urandom_range(1, 160));
            endcase
            load_settings(w, $urandom, $urandom);
            // last phase runs flat out on both sides
            if (ph == PHASES - 1)
                bursts_on = 1'b0;
            repeat (PHASE_ITEMS)
            begin
                // hold off now and then until every queued write has come back
                if (bursts_on && $urandom_range(0, 39) == 0)
                    wait_for_writes();
                send_cmd(random_cmd(), 1'b0, '0);
            end
        end

        wait_for_writes();
        repeat (END_CYCLES)
            @(posedge clk);
        $display("Sent %0d draw and %0d table load items over %0d register settings;",
                 draws_sent, loads_sent, settings_done);
        $display("checked %0d cell results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/msrf_pkg.sv
rtl/msrf_ctrl.sv
rtl/msrf_datapath.sv
rtl/masked_span_row_fill.sv
rtl/msrf_checker.sv
tb/tb.sv
